FILE: hdl/fcl_pkg.sv
// Shared types and constants of the fully connected layer.
// Command, kind and operation codes, sequencer states, pipeline token.
// No dependencies.
package fcl_pkg;

    localparam int MAX_DIM   = 64;
    localparam int DIM_BITS  = 6;
    localparam int MAX_BATCH = 16;
    localparam int ROW_BITS  = 4;
    localparam int DATA_BITS = 16;
    localparam int ACC_BITS  = 32;
    localparam int SUM_BITS  = 40;
    localparam int WADDR_BITS = 2 * DIM_BITS;
    localparam int AADDR_BITS = ROW_BITS + DIM_BITS;
    localparam int CELLS     = 4;
    localparam int WIDTH_BITS = 7;

    typedef enum logic [2:0] {
        CMD_LDW = 3'd0,
        CMD_LDB = 3'd1,
        CMD_FWD = 3'd2,
        CMD_BWD = 3'd3,
        CMD_RWG = 3'd4,
        CMD_RBG = 3'd5
    } cmd_t;

    // low two bits of the first four codes are the result kind
    typedef enum logic [2:0] {
        OP_FWD = 3'd0,
        OP_IG  = 3'd1,
        OP_RWG = 3'd2,
        OP_RBG = 3'd3,
        OP_WG  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD,
        ST_IG,
        ST_WG,
        ST_READ,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic                    valid;
        op_t                     op;
        logic                    first;
        logic                    fin;
        logic                    last;
        logic                    bterm;
        logic [DIM_BITS-1:0]     index;
        logic [WADDR_BITS-1:0]   waddr;
        logic [DIM_BITS-1:0]     baddr;
    } tok_t;

endpackage

FILE: hdl/fully_connected_layer.sv
// Fully connected layer top level: command sequencer, stores, token chain and MAC.
// Depends on fcl_pkg, fcl_cell and fcl_mac.
//
// Usage: present a command on cmd/batch_row/in_index/out_index/value with start
// high; it is taken at the edge where start is high and busy is low. A completed
// forward row runs output_width x input_width MAC steps, one per cycle, and emits
// output_width results; a completed backward row runs input_width x output_width
// steps for the input gradients, emitted as they finish, then the same count
// again to update the gradient accumulators. A gradient read emits one result.
// Results appear with strobe high for one cycle each; the receiver cannot stall.
// After each run busy stays high while the chain drains. The single MAC pipeline
// and the single-port weight store set the rate of one MAC per cycle. After
// reset, and on a backward element at batch row 0 and out index 0, a pass clears
// the weight gradient store; busy is high meanwhile.
// Configuration writes on the APB port are taken at any time.
module fully_connected_layer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [2:0]                             cmd,
    input  logic [fcl_pkg::ROW_BITS-1:0]           batch_row,
    input  logic [fcl_pkg::DIM_BITS-1:0]           in_index,
    input  logic [fcl_pkg::DIM_BITS-1:0]           out_index,
    input  logic signed [fcl_pkg::DATA_BITS-1:0]   value,
    output logic                                   strobe,
    output logic [1:0]                             kind,
    output logic [fcl_pkg::DIM_BITS-1:0]           index,
    output logic signed [fcl_pkg::DATA_BITS-1:0]   result_value,
    output logic                                   clipped,
    output logic                                   last,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import fcl_pkg::*;

    logic [DATA_BITS-1:0] wmem [MAX_DIM*MAX_DIM];
    logic [DATA_BITS-1:0] bmem [MAX_DIM];
    logic [DATA_BITS-1:0] amem [MAX_BATCH*MAX_DIM];
    logic [DATA_BITS-1:0] gmem [MAX_DIM];
    logic [ACC_BITS-1:0]  wgmem [MAX_DIM*MAX_DIM];
    logic [ACC_BITS-1:0]  bgmem [MAX_DIM];
    logic [MAX_DIM-1:0]   bg_valid_reg;

    logic [WIDTH_BITS-1:0] iw_reg;
    logic [WIDTH_BITS-1:0] ow_reg;
    logic [WIDTH_BITS-1:0] iw_use;
    logic [WIDTH_BITS-1:0] ow_use;
    logic [DIM_BITS-1:0]   iw_last;
    logic [DIM_BITS-1:0]   ow_last;

    state_t                state_reg, state_next;
    logic [DIM_BITS-1:0]   i_reg, i_next;
    logic [DIM_BITS-1:0]   j_reg, j_next;
    logic [WADDR_BITS-1:0] clr_reg, clr_next;
    logic [1:0]            drain_reg, drain_next;
    logic                  pend_reg, pend_next;
    logic                  clr_start;
    logic [ROW_BITS-1:0]   row_reg;
    logic [DIM_BITS-1:0]   ii_reg;
    logic [DIM_BITS-1:0]   oi_reg;
    logic [2:0]            cmd_reg;
    logic                  accept;
    logic                  cfg_we;

    tok_t                  tok [CELLS+1];

    logic [WADDR_BITS-1:0] wg_raddr;
    logic [DIM_BITS-1:0]   bg_raddr;
    logic signed [DATA_BITS-1:0] w_rd_reg, x_rd_reg, g_rd_reg, b_rd_reg;
    logic signed [ACC_BITS-1:0]  wg_rd_reg, bgm_rd_reg;
    logic                        bgv_rd_reg;
    logic signed [ACC_BITS-1:0]  bg_rd;
    logic signed [ACC_BITS-1:0]  wg_wdata, bg_wdata;
    logic                        wb_we;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= WIDTH_BITS'(MAX_DIM);
            ow_reg <= WIDTH_BITS'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            if (paddr[2])
            begin
                ow_reg <= pwdata[WIDTH_BITS-1:0];
            end
            else
            begin
                iw_reg <= pwdata[WIDTH_BITS-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? {{(32-WIDTH_BITS){1'b0}}, ow_reg}
                             : {{(32-WIDTH_BITS){1'b0}}, iw_reg};

    always_comb
    begin
        iw_use = (iw_reg == '0) ? WIDTH_BITS'(1)
               : (iw_reg > WIDTH_BITS'(MAX_DIM)) ? WIDTH_BITS'(MAX_DIM) : iw_reg;
        ow_use = (ow_reg == '0) ? WIDTH_BITS'(1)
               : (ow_reg > WIDTH_BITS'(MAX_DIM)) ? WIDTH_BITS'(MAX_DIM) : ow_reg;
        iw_last = DIM_BITS'(iw_use - WIDTH_BITS'(1));
        ow_last = DIM_BITS'(ow_use - WIDTH_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            i_reg     <= '0;
            j_reg     <= '0;
            clr_reg   <= '0;
            drain_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            clr_reg   <= clr_next;
            drain_reg <= drain_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= batch_row;
            ii_reg  <= in_index;
            oi_reg  <= out_index;
            cmd_reg <= cmd;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        clr_next   = clr_reg;
        drain_next = drain_reg;
        pend_next  = pend_reg;
        clr_start  = 1'b0;
        tok[0]     = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + WADDR_BITS'(1);
                i_next   = '0;
                j_next   = '0;
                if (clr_reg == {WADDR_BITS{1'b1}})
                begin
                    state_next = pend_reg ? ST_IG : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                i_next     = '0;
                j_next     = '0;
                drain_next = '0;
                clr_next   = '0;
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_FWD:
                        begin
                            if (in_index == iw_last)
                            begin
                                state_next = ST_FWD;
                            end
                        end
                        CMD_BWD:
                        begin
                            if (batch_row == '0 && out_index == '0)
                            begin
                                clr_start  = 1'b1;
                                state_next = ST_CLEAR;
                                pend_next  = (out_index == ow_last);
                            end
                            else if (out_index == ow_last)
                            begin
                                state_next = ST_IG;
                            end
                        end
                        CMD_RWG, CMD_RBG:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FWD:
            begin
                tok[0].valid = 1'b1;
                tok[0].op    = OP_FWD;
                tok[0].first = (i_reg == '0);
                tok[0].fin   = (i_reg == iw_last);
                tok[0].last  = (j_reg == ow_last);
                tok[0].index = j_reg;
                if (i_reg == iw_last)
                begin
                    i_next = '0;
                    j_next = j_reg + DIM_BITS'(1);
                    if (j_reg == ow_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    i_next = i_reg + DIM_BITS'(1);
                end
            end
            ST_IG:
            begin
                tok[0].valid = 1'b1;
                tok[0].op    = OP_IG;
                tok[0].first = (j_reg == '0);
                tok[0].fin   = (j_reg == ow_last);
                tok[0].last  = (i_reg == iw_last);
                tok[0].index = i_reg;
                if (j_reg == ow_last)
                begin
                    j_next = '0;
                    i_next = i_reg + DIM_BITS'(1);
                    if (i_reg == iw_last)
                    begin
                        i_next     = '0;
                        state_next = ST_WG;
                    end
                end
                else
                begin
                    j_next = j_reg + DIM_BITS'(1);
                end
            end
            ST_WG:
            begin
                tok[0].valid = 1'b1;
                tok[0].op    = OP_WG;
                tok[0].bterm = (i_reg == '0);
                tok[0].waddr = {i_reg, j_reg};
                tok[0].baddr = j_reg;
                if (i_reg == iw_last)
                begin
                    i_next = '0;
                    j_next = j_reg + DIM_BITS'(1);
                    if (j_reg == ow_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    i_next = i_reg + DIM_BITS'(1);
                end
            end
            ST_READ:
            begin
                tok[0].valid = 1'b1;
                tok[0].op    = (cmd_t'(cmd_reg) == CMD_RWG) ? OP_RWG : OP_RBG;
                tok[0].fin   = 1'b1;
                tok[0].last  = 1'b1;
                tok[0].index = oi_reg;
                state_next   = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wg_raddr = (state_reg == ST_READ) ? {ii_reg, oi_reg} : {i_reg, j_reg};
        bg_raddr = (state_reg == ST_READ) ? oi_reg : j_reg;
    end

    always_ff @(posedge clk)
    begin
        w_rd_reg   <= wmem[{i_reg, j_reg}];
        x_rd_reg   <= amem[{row_reg, i_reg}];
        g_rd_reg   <= gmem[j_reg];
        b_rd_reg   <= bmem[j_reg];
        wg_rd_reg  <= wgmem[wg_raddr];
        bgm_rd_reg <= bgmem[bg_raddr];
        bgv_rd_reg <= bg_valid_reg[bg_raddr];
    end

    assign bg_rd = bgv_rd_reg ? bgm_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (accept && cmd_t'(cmd) == CMD_LDW)
        begin
            wmem[{in_index, out_index}] <= value;
        end
        if (accept && cmd_t'(cmd) == CMD_LDB)
        begin
            bmem[out_index] <= value;
        end
        if (accept && cmd_t'(cmd) == CMD_FWD)
        begin
            amem[{batch_row, in_index}] <= value;
        end
        if (accept && cmd_t'(cmd) == CMD_BWD)
        begin
            gmem[out_index] <= value;
        end
    end

    assign wb_we = tok[2].valid && (tok[2].op == OP_WG);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            wgmem[clr_reg] <= '0;
        end
        else if (wb_we)
        begin
            wgmem[tok[2].waddr] <= wg_wdata;
        end
        if (wb_we && tok[2].bterm)
        begin
            bgmem[tok[2].baddr] <= bg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_valid_reg <= '0;
        end
        else if (clr_start)
        begin
            bg_valid_reg <= '0;
        end
        else if (wb_we && tok[2].bterm)
        begin
            bg_valid_reg[tok[2].baddr] <= 1'b1;
        end
    end

    for (genvar c = 0; c < CELLS; c++)
    begin : g_chain
        fcl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[c]),
            .tok_out (tok[c+1])
        );
    end

    fcl_mac u_mac (
        .clk       (clk),
        .tok1      (tok[1]),
        .tok2      (tok[2]),
        .tok3      (tok[3]),
        .w_rd      (w_rd_reg),
        .x_rd      (x_rd_reg),
        .g_rd      (g_rd_reg),
        .b_rd      (b_rd_reg),
        .wg_rd     (wg_rd_reg),
        .bg_rd     (bg_rd),
        .wg_wdata  (wg_wdata),
        .bg_wdata  (bg_wdata),
        .res_value (result_value),
        .res_clip  (clipped)
    );

    assign strobe = tok[CELLS].valid && tok[CELLS].fin;
    assign kind   = tok[CELLS].op[1:0];
    assign index  = tok[CELLS].index;
    assign last   = tok[CELLS].last;

    a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind[1] |-> last)
        else $error("gradient read result without last");

    a_no_wb_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wb_we |-> state_reg != ST_CLEAR)
        else $error("gradient writeback during clearing pass");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd_t'(cmd) == CMD_RWG || cmd_t'(cmd) == CMD_RBG) |=> ##4 strobe)
        else $error("gradient read result missing");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(tok[1].valid || tok[2].valid || tok[3].valid || tok[4].valid))
        else $error("block idle with transactions in flight");

endmodule

FILE: hdl/fcl_cell.sv
// One cell of the token chain: holds one in-flight token, passes it on.
// Depends on fcl_pkg.
module fcl_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  fcl_pkg::tok_t tok_in,
    output fcl_pkg::tok_t tok_out
);
    import fcl_pkg::*;

    tok_t tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hdl/fcl_mac.sv
// Multiply-accumulate datapath: product, accumulate, writeback sums, round and saturate.
// Depends on fcl_pkg; stages follow the token chain.
module fcl_mac (
    input  logic                                clk,
    input  fcl_pkg::tok_t                       tok1,
    input  fcl_pkg::tok_t                       tok2,
    input  fcl_pkg::tok_t                       tok3,
    input  logic signed [fcl_pkg::DATA_BITS-1:0] w_rd,
    input  logic signed [fcl_pkg::DATA_BITS-1:0] x_rd,
    input  logic signed [fcl_pkg::DATA_BITS-1:0] g_rd,
    input  logic signed [fcl_pkg::DATA_BITS-1:0] b_rd,
    input  logic signed [fcl_pkg::ACC_BITS-1:0]  wg_rd,
    input  logic signed [fcl_pkg::ACC_BITS-1:0]  bg_rd,
    output logic signed [fcl_pkg::ACC_BITS-1:0]  wg_wdata,
    output logic signed [fcl_pkg::ACC_BITS-1:0]  bg_wdata,
    output logic signed [fcl_pkg::DATA_BITS-1:0] res_value,
    output logic                                res_clip
);
    import fcl_pkg::*;

    function automatic logic [ACC_BITS-1:0] sat32(input logic [ACC_BITS:0] s);
        logic [ACC_BITS-1:0] r;
        if (s[ACC_BITS] != s[ACC_BITS-1])
        begin
            r = {s[ACC_BITS], {(ACC_BITS-1){~s[ACC_BITS]}}};
        end
        else
        begin
            r = s[ACC_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [DATA_BITS-1:0] op_a;
    logic signed [DATA_BITS-1:0] op_b;
    logic signed [ACC_BITS-1:0]  prod_reg;
    logic signed [ACC_BITS-1:0]  oldw_reg;
    logic signed [ACC_BITS-1:0]  oldb_reg;
    logic signed [DATA_BITS-1:0] g_reg;
    logic signed [DATA_BITS-1:0] bias_reg;
    logic signed [SUM_BITS-1:0]  acc_reg;
    logic signed [SUM_BITS-1:0]  acc_next;
    logic signed [SUM_BITS-1:0]  prod_ext;
    logic signed [SUM_BITS-1:0]  rnd;
    logic [ACC_BITS-1:0]         q;
    logic [ACC_BITS:0]           wsum;
    logic [ACC_BITS:0]           bsum;
    logic signed [DATA_BITS-1:0] res_value_reg;
    logic                        res_clip_reg;

    always_comb
    begin
        op_a = (tok1.op == OP_IG) ? g_rd : x_rd;
        op_b = (tok1.op == OP_WG) ? g_rd : w_rd;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        oldw_reg <= wg_rd;
        oldb_reg <= bg_rd;
        g_reg    <= g_rd;
        bias_reg <= b_rd;
    end

    always_comb
    begin
        wsum = {oldw_reg[ACC_BITS-1], oldw_reg} + {prod_reg[ACC_BITS-1], prod_reg};
        bsum = {oldb_reg[ACC_BITS-1], oldb_reg}
             + {{(ACC_BITS-DATA_BITS+1){g_reg[DATA_BITS-1]}}, g_reg};
        wg_wdata = sat32(wsum);
        bg_wdata = sat32(bsum);
        prod_ext = {{(SUM_BITS-ACC_BITS){prod_reg[ACC_BITS-1]}}, prod_reg};
        case (tok2.op)
            OP_FWD:
            begin
                acc_next = (tok2.first
                    ? {{(SUM_BITS-DATA_BITS-8){bias_reg[DATA_BITS-1]}}, bias_reg, 8'b0}
                    : acc_reg) + prod_ext;
            end
            OP_IG:
            begin
                acc_next = (tok2.first ? '0 : acc_reg) + prod_ext;
            end
            OP_RWG:
            begin
                acc_next = {{(SUM_BITS-ACC_BITS){oldw_reg[ACC_BITS-1]}}, oldw_reg};
            end
            OP_RBG:
            begin
                acc_next = {oldb_reg, 8'b0};
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tok2.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        rnd = acc_reg + SUM_BITS'(128);
        q   = rnd[SUM_BITS-1:8];
    end

    always_ff @(posedge clk)
    begin
        if (tok3.valid)
        begin
            if (q[ACC_BITS-1:DATA_BITS-1] != {(ACC_BITS-DATA_BITS+1){q[ACC_BITS-1]}})
            begin
                res_value_reg <= {q[ACC_BITS-1], {(DATA_BITS-1){~q[ACC_BITS-1]}}};
                res_clip_reg  <= 1'b1;
            end
            else
            begin
                res_value_reg <= q[DATA_BITS-1:0];
                res_clip_reg  <= 1'b0;
            end
        end
    end

    assign res_value = res_value_reg;
    assign res_clip  = res_clip_reg;

endmodule
